// ===== hdl/wcs_pkg.sv =====
// Package with widths, codes and shared types of the wall-clock sync and stamp unit.
`timescale 1ns / 1ps

package wcs_pkg;

    localparam int TIME_WIDTH  = 48;
    localparam int COUNT_WIDTH = 32;
    localparam int REG_INDEX_WIDTH = 2;

    typedef logic [TIME_WIDTH-1:0]      time_t;
    typedef logic [COUNT_WIDTH-1:0]     count_t;
    typedef logic [REG_INDEX_WIDTH-1:0] reg_index_t;
    typedef logic [1:0]                 quality_t;

    localparam time_t MIN_WALL_RESET   = TIME_WIDTH'(64'd1577836800000);
    localparam time_t MAX_WALL_RESET   = TIME_WIDTH'(64'd4102444800000);
    localparam time_t STALE_AFTER_RESET = TIME_WIDTH'(64'd3600000);

    localparam reg_index_t REG_MIN_WALL    = 2'd0;
    localparam reg_index_t REG_MAX_WALL    = 2'd1;
    localparam reg_index_t REG_STALE_AFTER = 2'd2;

    localparam logic ACTION_SYNC  = 1'b0;
    localparam logic ACTION_STAMP = 1'b1;

    localparam quality_t QUALITY_UNSYNC = 2'd0;
    localparam quality_t QUALITY_SYNC   = 2'd1;
    localparam quality_t QUALITY_STALE  = 2'd2;

    typedef struct packed {
        logic  action;
        time_t uptime;
        time_t wall;
    } item_t;

    typedef struct packed {
        time_t min_wall;
        time_t max_wall;
        time_t stale_after;
    } limits_t;

    typedef struct packed {
        time_t  ref_uptime;
        time_t  ref_wall;
        count_t accept_count;
        count_t reject_count;
    } ref_state_t;

    typedef struct packed {
        logic     sync_accepted;
        time_t    uptime;
        time_t    wall;
        quality_t quality;
        count_t   accepted_total;
        count_t   rejected_total;
    } result_t;

endpackage

// ===== hdl/wcs_stamp_logic.sv =====
// Combinational sync check, reference update and time stamp derivation for one item.
`timescale 1ns / 1ps

module wcs_stamp_logic (
    input  wcs_pkg::item_t      item,
    input  wcs_pkg::limits_t    limits,
    input  wcs_pkg::ref_state_t state,
    output wcs_pkg::ref_state_t state_next,
    output wcs_pkg::result_t    result
);

    logic          wall_lt_min;
    logic          wall_ge_max;
    logic          has_ref;
    logic          uptime_back;
    logic          ref_in_window;
    logic          stamp_ok;
    wcs_pkg::time_t age;
    wcs_pkg::time_t room;

    assign wall_lt_min   = item.wall < limits.min_wall;
    assign wall_ge_max   = item.wall >= limits.max_wall;
    assign has_ref       = state.accept_count != '0;
    assign uptime_back   = item.uptime < state.ref_uptime;
    assign ref_in_window = (state.ref_wall >= limits.min_wall)
                           && (state.ref_wall < limits.max_wall);
    assign age           = item.uptime - state.ref_uptime;
    assign room          = limits.max_wall - state.ref_wall;
    assign stamp_ok      = has_ref && !uptime_back && ref_in_window && (age < room);

    always_comb
    begin
        state_next            = state;
        result.sync_accepted  = 1'b0;
        result.uptime         = item.uptime;
        result.wall           = '0;
        result.quality        = wcs_pkg::QUALITY_UNSYNC;

        if (item.action == wcs_pkg::ACTION_SYNC)
        begin
            if (wall_lt_min || wall_ge_max || (has_ref && uptime_back))
            begin
                if (state.reject_count != '1)
                begin
                    state_next.reject_count = state.reject_count + 1'b1;
                end
            end
            else
            begin
                state_next.ref_uptime = item.uptime;
                state_next.ref_wall   = item.wall;
                if (state.accept_count != '1)
                begin
                    state_next.accept_count = state.accept_count + 1'b1;
                end
                result.sync_accepted = 1'b1;
            end
        end
        else if (stamp_ok)
        begin
            result.wall    = state.ref_wall + age;
            result.quality = (age > limits.stale_after) ? wcs_pkg::QUALITY_STALE
                                                        : wcs_pkg::QUALITY_SYNC;
        end

        result.accepted_total = state_next.accept_count;
        result.rejected_total = state_next.reject_count;
    end

endmodule

// ===== hdl/wall_clock_sync_and_stamp_unit.sv =====
// Top level of the wall-clock sync and stamp unit: input stage, state, limits and result stage.
`timescale 1ns / 1ps

// The unit takes one transaction per clock cycle while the output is not stalled, and returns
// exactly one result per transaction, presented from the result register after the transaction
// has passed through the input register. An accepted transaction lands in that register; while
// it is held there, the compare, subtract and add logic works on it against the stored reference
// pair and the limit registers, and when the output can take a result it updates the reference
// and counters and loads the result register. in_ready follows out_ready combinationally, so a
// stalled output stops intake only once both stages hold a transaction.
// Configuration writes are always ready; they should be issued only while the unit is idle.
// A write to an index other than the three limit registers is ignored.

module wall_clock_sync_and_stamp_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [wcs_pkg::TIME_WIDTH-1:0] uptime_now,
    input  logic [wcs_pkg::TIME_WIDTH-1:0] wall_time_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        sync_accepted,
    output logic [wcs_pkg::TIME_WIDTH-1:0] stamp_uptime,
    output logic [wcs_pkg::TIME_WIDTH-1:0] stamp_wall_time,
    output logic [1:0]                  quality,
    output logic [wcs_pkg::COUNT_WIDTH-1:0] accepted_total,
    output logic [wcs_pkg::COUNT_WIDTH-1:0] rejected_total,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wcs_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [wcs_pkg::TIME_WIDTH-1:0] cfg_data
);

    logic                stage_valid_reg;
    wcs_pkg::item_t      stage_item_reg;
    logic                out_valid_reg;
    wcs_pkg::result_t    result_reg;
    wcs_pkg::result_t    result_next;
    wcs_pkg::ref_state_t state_reg;
    wcs_pkg::ref_state_t state_next;
    wcs_pkg::limits_t    limits_reg;
    logic                advance;

    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign cfg_ready = 1'b1;

    wcs_stamp_logic u_stamp_logic (
        .item       (stage_item_reg),
        .limits     (limits_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '0;
            limits_reg.min_wall    <= wcs_pkg::MIN_WALL_RESET;
            limits_reg.max_wall    <= wcs_pkg::MAX_WALL_RESET;
            limits_reg.stale_after <= wcs_pkg::STALE_AFTER_RESET;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wcs_pkg::REG_MIN_WALL:    limits_reg.min_wall    <= cfg_data;
                    wcs_pkg::REG_MAX_WALL:    limits_reg.max_wall    <= cfg_data;
                    wcs_pkg::REG_STALE_AFTER: limits_reg.stale_after <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg.action <= action;
            stage_item_reg.uptime <= uptime_now;
            stage_item_reg.wall   <= wall_time_in;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sync_accepted   = result_reg.sync_accepted;
    assign stamp_uptime    = result_reg.uptime;
    assign stamp_wall_time = result_reg.wall;
    assign quality         = result_reg.quality;
    assign accepted_total  = result_reg.accepted_total;
    assign rejected_total  = result_reg.rejected_total;

endmodule

// ===== hdl/wcs_checker.sv =====
// Port-level assertion checker for the wall-clock sync and stamp unit, with its bind.
`timescale 1ns / 1ps

module wcs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        sync_accepted,
    input logic [wcs_pkg::TIME_WIDTH-1:0] stamp_uptime,
    input logic [wcs_pkg::TIME_WIDTH-1:0] stamp_wall_time,
    input logic [1:0]                  quality,
    input logic [wcs_pkg::COUNT_WIDTH-1:0] accepted_total,
    input logic [wcs_pkg::COUNT_WIDTH-1:0] rejected_total
);

    // A stalled result transaction keeps its stamp, quality and counter fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(stamp_uptime)
            && $stable(stamp_wall_time) && $stable(quality)
            && $stable(accepted_total) && $stable(rejected_total))
        else $error("stalled result transaction changed");

    // An accepted sync never carries a time stamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sync_accepted |->
            quality == wcs_pkg::QUALITY_UNSYNC && stamp_wall_time == '0)
        else $error("accepted sync carries a time stamp");

    // An unsynchronized result reports wall time zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quality == wcs_pkg::QUALITY_UNSYNC |-> stamp_wall_time == '0)
        else $error("unsynchronized result with nonzero wall time");

    // A graded stamp requires at least one accepted sync.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quality != wcs_pkg::QUALITY_UNSYNC |->
            !sync_accepted && accepted_total != '0)
        else $error("graded stamp without an accepted sync");

endmodule

bind wall_clock_sync_and_stamp_unit wcs_checker u_wcs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sync_accepted   (sync_accepted),
    .stamp_uptime    (stamp_uptime),
    .stamp_wall_time (stamp_wall_time),
    .quality         (quality),
    .accepted_total  (accepted_total),
    .rejected_total  (rejected_total)
);
